// ----- sv/qlt_pkg.sv -----
`default_nettype none
package qlt_pkg;

	localparam int unsigned MaxRes = 3;

	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;

	localparam logic [1:0] TOK_MAX = 2'd3;

	typedef enum logic [2:0] {
		MODE_NORMAL  = 3'd0,
		MODE_QUOTED  = 3'd1,
		MODE_QESC    = 3'd2,
		MODE_BSLASH  = 3'd3,
		MODE_CHUG    = 3'd4,
		MODE_COMMENT = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		KIND_CHAR    = 2'd0,
		KIND_TOKEND  = 2'd1,
		KIND_LINEEND = 2'd2,
		KIND_WARN    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		WARN_NONE       = 2'd0,
		WARN_EOI_BSLASH = 2'd1,
		WARN_ESCAPE     = 2'd2
	} warn_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic [1:0] lt;
		warn_t      wc;
	} res_t;

	// results caused by one request, res[0] goes out first
	typedef struct packed {
		logic [1:0]          cnt;
		res_t [MaxRes-1:0]   res;
	} bundle_t;

endpackage
`default_nettype wire

// ----- sv/qlt_lexer.sv -----
`default_nettype none
module qlt_lexer (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [7:0]      byte_in,
	input  wire logic            eoi,
	input  wire logic            adv,
	output qlt_pkg::bundle_t     bundle
);
	import qlt_pkg::*;

	mode_t      mode_q, mode_d;
	logic       open_q, open_d;
	logic [1:0] cnt_q, cnt_d;
	logic [1:0] n;
	logic       norm;
	res_t       res [MaxRes];

	always_comb begin
		mode_d = mode_q;
		open_d = open_q;
		cnt_d  = cnt_q;
		n      = 2'd0;
		norm   = 1'b0;
		for (int i = 0; i < MaxRes; i++) begin
			res[i] = '{kind: KIND_CHAR, ch: 8'h00, lt: 2'd0, wc: WARN_NONE};
		end

		if (eoi) begin
			if (mode_q == MODE_BSLASH || mode_q == MODE_QESC) begin
				res[n] = '{kind: KIND_WARN, ch: 8'h00, lt: 2'd0, wc: WARN_EOI_BSLASH};
				n = n + 2'd1;
			end
			if (open_d) begin
				if (cnt_d != TOK_MAX)
					cnt_d = cnt_d + 2'd1;
				res[n] = '{kind: KIND_TOKEND, ch: 8'h00, lt: 2'd0, wc: WARN_NONE};
				n = n + 2'd1;
			end
			res[n] = '{kind: KIND_LINEEND, ch: 8'h00, lt: cnt_d, wc: WARN_NONE};
			n = n + 2'd1;
			mode_d = MODE_NORMAL;
			open_d = 1'b0;
			cnt_d  = 2'd0;
		end else begin
			case (mode_q)
				MODE_QUOTED: begin
					if (byte_in == CH_QUOTE) begin
						mode_d = MODE_NORMAL;
					end else if (byte_in == CH_BSLASH) begin
						mode_d = MODE_QESC;
					end else begin
						open_d = 1'b1;
						res[n] = '{kind: KIND_CHAR, ch: byte_in, lt: 2'd0, wc: WARN_NONE};
						n = n + 2'd1;
					end
				end
				MODE_QESC: begin
					if (byte_in != CH_BSLASH && byte_in != CH_QUOTE) begin
						res[n] = '{kind: KIND_WARN, ch: 8'h00, lt: 2'd0, wc: WARN_ESCAPE};
						n = n + 2'd1;
					end
					open_d = 1'b1;
					res[n] = '{kind: KIND_CHAR, ch: byte_in, lt: 2'd0, wc: WARN_NONE};
					n = n + 2'd1;
					mode_d = MODE_QUOTED;
				end
				MODE_BSLASH: begin
					if (byte_in == CH_NL) begin
						mode_d = MODE_CHUG;
					end else begin
						// keep the backslash, then process the byte as in normal mode
						open_d = 1'b1;
						res[n] = '{kind: KIND_CHAR, ch: CH_BSLASH, lt: 2'd0, wc: WARN_NONE};
						n = n + 2'd1;
						mode_d = MODE_NORMAL;
						norm = 1'b1;
					end
				end
				MODE_CHUG: begin
					if (byte_in != CH_SPACE && byte_in != CH_TAB) begin
						mode_d = MODE_NORMAL;
						norm = 1'b1;
					end
				end
				MODE_COMMENT: begin
					if (byte_in == CH_NL) begin
						mode_d = MODE_NORMAL;
						res[n] = '{kind: KIND_LINEEND, ch: 8'h00, lt: cnt_d, wc: WARN_NONE};
						n = n + 2'd1;
						cnt_d = 2'd0;
					end
				end
				default: begin
					mode_d = MODE_NORMAL;
					norm = 1'b1;
				end
			endcase

			if (norm) begin
				if (byte_in == CH_HASH || byte_in == CH_NL
						|| byte_in == CH_SPACE || byte_in == CH_TAB) begin
					if (open_d) begin
						open_d = 1'b0;
						if (cnt_d != TOK_MAX)
							cnt_d = cnt_d + 2'd1;
						res[n] = '{kind: KIND_TOKEND, ch: 8'h00, lt: 2'd0, wc: WARN_NONE};
						n = n + 2'd1;
					end
					if (byte_in == CH_HASH) begin
						mode_d = MODE_COMMENT;
					end else if (byte_in == CH_NL) begin
						res[n] = '{kind: KIND_LINEEND, ch: 8'h00, lt: cnt_d, wc: WARN_NONE};
						n = n + 2'd1;
						cnt_d = 2'd0;
					end
				end else if (byte_in == CH_BSLASH) begin
					mode_d = MODE_BSLASH;
				end else if (byte_in == CH_QUOTE) begin
					mode_d = MODE_QUOTED;
				end else begin
					open_d = 1'b1;
					res[n] = '{kind: KIND_CHAR, ch: byte_in, lt: 2'd0, wc: WARN_NONE};
					n = n + 2'd1;
				end
			end
		end
	end

	always_comb begin
		bundle.cnt = n;
		for (int i = 0; i < MaxRes; i++) begin
			bundle.res[i] = res[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			open_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else if (adv) begin
			mode_q <= mode_d;
			open_q <= open_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule
`default_nettype wire

// ----- sv/qlt_outbuf.sv -----
`default_nettype none
module qlt_outbuf (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire qlt_pkg::bundle_t bundle,
	input  wire logic             load,
	output logic                  can_load,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output qlt_pkg::res_t         res,
	output logic                  last
);
	import qlt_pkg::*;

	bundle_t    buf_q;
	logic       valid_q;
	logic [1:0] idx_q;
	logic       take;
	logic       done;

	assign out_valid = valid_q;
	assign res       = buf_q.res[idx_q];
	assign last      = (idx_q == buf_q.cnt - 2'd1);
	assign take      = valid_q && !out_stall;
	assign done      = take && last;
	assign can_load  = !valid_q || done;

	always_ff @(posedge clk) begin
		if (load)
			buf_q <= bundle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (done) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (take) begin
			idx_q   <= idx_q + 2'd1;
		end
	end

endmodule
`default_nettype wire

// ----- sv/quoted_line_tokenizer_unit.sv -----
// A request waits in the input register; its results from the lexer go into
// the single output register. One request per cycle, while out_stall is low,
// when it yields at most one result; a request that yields more holds the
// output register, one result per cycle unless stalled; empty requests skip it.
// Reset (arst_n low, asynchronous): lexer returns to normal mode, no open
// token, count zero; input and output registers empty.
`default_nettype none
module quoted_line_tokenizer_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] byte_value,
	input  wire logic       end_of_input,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      kind,
	output logic [7:0]      char_out,
	output logic [1:0]      line_tokens,
	output logic [1:0]      warning_code,
	output logic            last
);
	import qlt_pkg::*;

	logic [7:0] byte_s1;
	logic       eoi_s1;
	logic       v_s1;
	bundle_t    bundle;
	logic       can_load;
	logic       adv;
	logic       load;
	logic       accept;
	res_t       res;

	assign adv      = v_s1 && (bundle.cnt == 2'd0 || can_load);
	assign load     = adv && (bundle.cnt != 2'd0);
	assign in_stall = v_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= byte_value;
			eoi_s1  <= end_of_input;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (accept)
			v_s1 <= 1'b1;
		else if (adv)
			v_s1 <= 1'b0;
	end

	qlt_lexer u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_s1),
		.eoi     (eoi_s1),
		.adv     (adv),
		.bundle  (bundle)
	);

	qlt_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.bundle    (bundle),
		.load      (load),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res),
		.last      (last)
	);

	assign kind         = res.kind;
	assign char_out     = res.ch;
	assign line_tokens  = res.lt;
	assign warning_code = res.wc;

endmodule
`default_nettype wire

// ----- sv/qlt_checker.sv -----
`default_nettype none
module qlt_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [7:0] byte_value,
	input wire logic       end_of_input,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [1:0] kind,
	input wire logic [7:0] char_out,
	input wire logic [1:0] line_tokens,
	input wire logic [1:0] warning_code,
	input wire logic       last
);
	import qlt_pkg::*;

	// stalled request holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(byte_value) && $stable(end_of_input))
		else $error("stalled request changed");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(char_out)
			&& $stable(line_tokens) && $stable(warning_code) && $stable(last))
		else $error("stalled result changed");

	// results of one request come out back to back
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("gap inside a result burst");

	// a line end always closes its request, a warning never does
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_LINEEND || kind == KIND_WARN)
			|-> (last == (kind == KIND_LINEEND)))
		else $error("line end or warning out of place");

	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == KIND_CHAR || char_out == 8'h00)
			&& (kind == KIND_LINEEND || line_tokens == 2'd0)
			&& ((kind == KIND_WARN) == (warning_code != WARN_NONE)))
		else $error("unused result field not zero");

endmodule

bind quoted_line_tokenizer_unit qlt_checker u_qlt_checker (.*);
`default_nettype wire
